// File: rtl/mkvc_pkg.sv
// Package for the MRU key/value cache: sizes, opcode codes and the structs
// passed between the top level and the row of storage cells.
// No dependencies.
package mkvc_pkg;

   localparam int DEPTH  = 16;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 5;
   localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   // Command presented to one cell in the execute cycle.
   typedef struct packed {
      logic             write;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } cell_cmd_type;

   // Local status of one cell.
   typedef struct packed {
      logic valid;
      logic match;
      logic first_free;
   } cell_stat_type;

   // Signals handed from one cell to the next along the row.
   typedef struct packed {
      logic             seen_free;
      logic             seen_hit;
      logic [VAL_W-1:0] value;
   } chain_type;

endpackage

// File: rtl/mkvc_cell.sv
// One storage cell of the MRU key/value cache: key, value and valid mark.
// Depends on mkvc_pkg for the command, status and chain structs.
module mkvc_cell import mkvc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd_in,
   input  chain_type     chain_in,
   output chain_type     chain_out,
   output cell_stat_type stat_out
);

   logic             valid_ff;
   logic             valid_in;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic             match;

   assign match    = valid_ff && (key_ff == cmd_in.key);
   assign valid_in = valid_ff | cmd_in.write;

   // The lowest matching cell drives the read value; a miss keeps what came in.
   always_comb begin
      chain_out.seen_free = chain_in.seen_free | ~valid_ff;
      chain_out.seen_hit  = chain_in.seen_hit | match;
      chain_out.value     = (match && !chain_in.seen_hit) ? value_ff : chain_in.value;
      stat_out.valid      = valid_ff;
      stat_out.match      = match;
      stat_out.first_free = ~valid_ff & ~chain_in.seen_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.write) begin
         key_ff   <= cmd_in.key;
         value_ff <= cmd_in.value;
      end
   end

endmodule

// File: rtl/mru_key_value_cache_unit.sv
// Top level of the MRU key/value cache: request register, a row of mkvc_cell
// storage cells, fill count, recent-slot pointer and the result register.
// Depends on mkvc_pkg and mkvc_cell.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------------
//   req     | in        | req_tvalid / req_tready  | tuser: opcode; tdata: key, value
//   rsp     | out       | rsp_tvalid / rsp_tready  | tuser: hit; tdata: read_value
//   csr     | in        | csr_valid / csr_ready    | csr_data: capacity
//
// Each request is first transferred into the request register, and then the
// execute step runs the compare along the cell row and writes back.
// A get stays in its execute cycle while the result register is still full and
// not being taken; a put never waits. A result waits in its register while the
// next request is transferred. Reset (synchronous) clears all valid marks, the
// fill count and the recent pointer at once and sets the capacity to 16.
module mru_key_value_cache_unit import mkvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // Request channel.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [0:0]       req_tuser,   // [0] opcode (0 get, 1 put)
   input  logic [63:0]      req_tdata,   // [31:0] lookup_key, [63:32] store_value
   // Result channel.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [0:0]       rsp_tuser,   // [0] hit
   output logic [31:0]      rsp_tdata,   // [31:0] read_value
   // Capacity register write channel.
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   // Request register.
   logic             busy_ff, busy_in;
   opcode_type       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] store_ff;

   // Control state.
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] recent_ff, recent_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   // Cell row.
   cell_cmd_type  cmd   [DEPTH];
   cell_stat_type stat  [DEPTH];
   chain_type     chain [DEPTH+1];
   logic [DEPTH-1:0] match_vec, free_vec, valid_vec, write_vec, sel_vec;

   logic             exec;
   logic             is_put;
   logic             hit_any;
   logic             use_free;
   logic             fill_inc;
   logic [CMP_W-1:0] eff_cap;
   logic [SLOT_W-1:0] sel_slot;

   assign req_tready = ~busy_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_value_ff;

   assign is_put = (op_ff == OP_PUT);
   // A get needs room in the result register; a put gives no result.
   assign exec   = busy_ff && (is_put || !rsp_valid_ff || rsp_tready);

   // The row starts with nothing seen and an all-ones value, which is the miss value.
   assign chain[0] = '{seen_free: 1'b0, seen_hit: 1'b0, value: '1};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign cmd[g] = '{write: write_vec[g], key: key_ff, value: store_ff};
      assign match_vec[g] = stat[g].match;
      assign free_vec[g]  = stat[g].first_free;
      assign valid_vec[g] = stat[g].valid;

      mkvc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd_in    (cmd[g]),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .stat_out  (stat[g])
      );
   end

   assign hit_any = chain[DEPTH].seen_hit;

   // Capacity zero counts as one; anything above the cell count is clipped.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   // A new key takes the lowest free cell while below capacity, else it
   // replaces the most recent entry in place.
   assign use_free = (CMP_W'(fill_ff) < eff_cap) && chain[DEPTH].seen_free;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (hit_any) begin
            write_vec[i] = exec && is_put && match_vec[i];
         end else if (use_free) begin
            write_vec[i] = exec && is_put && free_vec[i];
         end else begin
            write_vec[i] = exec && is_put && (recent_ff == SLOT_W'(i));
         end
      end
   end

   assign fill_inc = exec && is_put && !hit_any && (use_free || !valid_vec[recent_ff]);
   assign sel_vec  = is_put ? write_vec : match_vec;

   // One-hot to index; at most one bit of sel_vec is set.
   always_comb begin
      sel_slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (sel_vec[i]) begin
            sel_slot = sel_slot | SLOT_W'(i);
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      fill_in   = fill_ff;
      recent_in = recent_ff;
      cap_in    = cap_ff;
      if (req_tvalid && req_tready) begin
         busy_in = 1'b1;
      end else if (exec) begin
         busy_in = 1'b0;
      end
      if (fill_inc) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if (exec && (is_put || hit_any)) begin
         recent_in = sel_slot;
      end
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
      if (exec && !is_put) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fill_ff      <= '0;
         recent_ff    <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         fill_ff      <= fill_in;
         recent_ff    <= recent_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= opcode_type'(req_tuser[0]);
         key_ff   <= req_tdata[KEY_W-1:0];
         store_ff <= req_tdata[KEY_W+VAL_W-1:KEY_W];
      end
      if (exec && !is_put) begin
         rsp_hit_ff   <= hit_any;
         rsp_value_ff <= chain[DEPTH].value;
      end
   end

   // The fill count never exceeds the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(DEPTH))
      else $error("fill count above cell count");

   // At most one cell is written per request.
   assert property (@(posedge clock) disable iff (reset) $onehot0(write_vec))
      else $error("more than one cell written");

   // A result appears only after a get has executed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec && !is_put))
      else $error("result without an executed get");

   // A get never changes the fill count.
   assert property (@(posedge clock) disable iff (reset)
      (exec && !is_put) |=> $stable(fill_ff))
      else $error("get changed the fill count");

endmodule
